### rtl/core/dense_neuron_requantize_assert.svh
// Assertion macros shared by the dense neuron requantizer RTL.
`ifndef DENSE_NEURON_REQUANTIZE_ASSERT_SVH
`define DENSE_NEURON_REQUANTIZE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define DNR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define DNR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/dnr_pkg.sv
`timescale 1ns / 1ps

package dnr_pkg;

   localparam int WEIGHT_WIDTH     = 16;
   localparam int ACT_WIDTH        = 16;
   localparam int BIAS_WIDTH       = 32;
   localparam int OUT_WIDTH        = 16;
   localparam int ACC_WIDTH        = 64;
   localparam int MUL_WIDTH        = 32;
   localparam int MULT_WIDTH       = 32;
   localparam int SHIFT_WIDTH      = 6;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH   = 32;

   localparam logic signed [MULT_WIDTH-1:0] MULT_RESET  = 32'sd1;
   localparam logic [SHIFT_WIDTH-1:0]       SHIFT_RESET = 6'd16;
   localparam logic                         RELU_RESET  = 1'b1;

   localparam logic signed [OUT_WIDTH-1:0]  OUT_MAX = 16'sh7fff;
   localparam logic signed [OUT_WIDTH-1:0]  OUT_MIN = 16'sh8000;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_REQUANT_MULT = 2'd0,
      CSR_SHIFT_AMOUNT = 2'd1,
      CSR_RELU_ENABLE  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAC,
      S_ACC,
      S_RQ_LO,
      S_RQ_HI,
      S_MERGE,
      S_BIAS,
      S_SHIFT
   } state_type;

endpackage

### rtl/core/dense_neuron_requantize.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_weight, req_activation, req_bias_value,
//                                           req_last_term
// rsp       out        rsp_valid/rsp_stall  rsp_neuron_out
// csr       in         csr_valid/csr_ready  csr_index, csr_data
//
// A term that is not last passes through multiply and accumulate, then back to idle.
// A last term also runs the 64x32 scaling as two passes through
// the one registered 32x32 multiplier, then merge, bias add and shift/saturate.
// The block takes no new request until the sequencer is back in idle.
// Synchronous active-high reset clears the sequencer, accumulator and rsp_valid, and loads the CSR reset values.
// A stalled result holds in the output register; a following result waits for it.
`include "dense_neuron_requantize_assert.svh"

module dense_neuron_requantize (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic signed [dnr_pkg::WEIGHT_WIDTH-1:0]    req_weight,
   input  logic signed [dnr_pkg::ACT_WIDTH-1:0]       req_activation,
   input  logic signed [dnr_pkg::BIAS_WIDTH-1:0]      req_bias_value,
   input  logic                                       req_last_term,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [dnr_pkg::OUT_WIDTH-1:0]       rsp_neuron_out,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [dnr_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [dnr_pkg::CSR_DATA_WIDTH-1:0]         csr_data
);
   import dnr_pkg::*;

   state_type state_ff, state_in;

   logic signed [MULT_WIDTH-1:0]    mult_ff;
   logic [SHIFT_WIDTH-1:0]          shift_ff;
   logic                            relu_ff;

   logic [WEIGHT_WIDTH-1:0]         weight_ff;
   logic [ACT_WIDTH-1:0]            act_ff;
   logic [BIAS_WIDTH-1:0]           bias_ff;
   logic                            last_ff;

   logic [ACC_WIDTH-1:0]            acc_ff, acc_in;
   logic [ACC_WIDTH-1:0]            t_ff, t_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_WIDTH-1:0]     rsp_data_ff, rsp_data_in;

   logic [MUL_WIDTH-1:0]            mul_a, mul_b;
   logic [2*MUL_WIDTH-1:0]          mul_p;

   logic                            req_take;
   logic                            rsp_free;
   logic [MUL_WIDTH-1:0]            hi_word;
   logic [ACC_WIDTH-1:0]            bias_term;
   logic [ACC_WIDTH-1:0]            round_term;
   logic signed [ACC_WIDTH-1:0]     shifted;
   logic                            too_big;
   logic                            too_small;

   dnr_mul32 u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_take) state_in = S_MAC;
         S_MAC:   state_in = S_ACC;
         S_ACC:   state_in = last_ff ? S_RQ_LO : S_IDLE;
         S_RQ_LO: state_in = S_RQ_HI;
         S_RQ_HI: state_in = S_MERGE;
         S_MERGE: state_in = S_BIAS;
         S_BIAS:  state_in = S_SHIFT;
         S_SHIFT: if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs: multiplier operand select and input stall
   always_comb begin
      req_stall = 1'b1;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         S_IDLE: req_stall = 1'b0;
         S_MAC: begin
            mul_a = {{(MUL_WIDTH-WEIGHT_WIDTH){weight_ff[WEIGHT_WIDTH-1]}}, weight_ff};
            mul_b = {{(MUL_WIDTH-ACT_WIDTH){act_ff[ACT_WIDTH-1]}}, act_ff};
         end
         S_RQ_LO: begin
            mul_a = acc_ff[MUL_WIDTH-1:0];
            mul_b = mult_ff;
         end
         S_RQ_HI: begin
            mul_a = acc_ff[ACC_WIDTH-1:MUL_WIDTH];
            mul_b = mult_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // upper word of the scaled sum; a negative multiplier subtracts the low word once
   assign hi_word = mul_p[MUL_WIDTH-1:0]
                    - (mult_ff[MULT_WIDTH-1] ? acc_ff[MUL_WIDTH-1:0] : {MUL_WIDTH{1'b0}});

   assign bias_term  = {{(ACC_WIDTH-BIAS_WIDTH){bias_ff[BIAS_WIDTH-1]}}, bias_ff} << shift_ff;
   assign round_term = (ACC_WIDTH'(1) << shift_ff) >> 1;

   assign shifted   = $signed(t_ff) >>> shift_ff;
   assign too_big   = !shifted[ACC_WIDTH-1] && (|shifted[ACC_WIDTH-2:OUT_WIDTH-1]);
   assign too_small = shifted[ACC_WIDTH-1] && !(&shifted[ACC_WIDTH-2:OUT_WIDTH-1]);

   always_comb begin
      acc_in = acc_ff;
      t_in   = t_ff;
      unique case (state_ff)
         S_ACC: begin
            acc_in = acc_ff + {{(ACC_WIDTH-MUL_WIDTH){mul_p[MUL_WIDTH-1]}},
                               mul_p[MUL_WIDTH-1:0]};
         end
         S_RQ_HI: t_in = mul_p;
         S_MERGE: t_in = t_ff + {hi_word, {MUL_WIDTH{1'b0}}};
         S_BIAS: begin
            // rounding bit lies below the bias shift, so OR replaces an add
            t_in   = t_ff + (bias_term | round_term);
            acc_in = '0;
         end
         default: begin
            acc_in = acc_ff;
            t_in   = t_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_SHIFT && rsp_free) begin
         rsp_valid_in = 1'b1;
         priority if (relu_ff && shifted[ACC_WIDTH-1]) begin
            rsp_data_in = '0;
         end else if (too_big) begin
            rsp_data_in = OUT_MAX;
         end else if (too_small) begin
            rsp_data_in = OUT_MIN;
         end else begin
            rsp_data_in = shifted[OUT_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         mult_ff      <= MULT_RESET;
         shift_ff     <= SHIFT_RESET;
         relu_ff      <= RELU_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_REQUANT_MULT: mult_ff  <= csr_data[MULT_WIDTH-1:0];
               CSR_SHIFT_AMOUNT: shift_ff <= csr_data[SHIFT_WIDTH-1:0];
               CSR_RELU_ENABLE:  relu_ff  <= csr_data[0];
               default:          relu_ff  <= relu_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         weight_ff <= req_weight;
         act_ff    <= req_activation;
         bias_ff   <= req_bias_value;
         last_ff   <= req_last_term;
      end
      t_ff        <= t_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_neuron_out = rsp_data_ff;

   `DNR_ASSERT_SAME(a_acc_clear_at_out, clock, reset, state_ff == S_SHIFT, acc_ff == '0,
      "accumulator not cleared before result")
   `DNR_ASSERT_SAME(a_rsp_from_shift, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == S_SHIFT, "result appeared outside the shift step")
   `DNR_ASSERT_NEXT(a_hold_when_blocked, clock, reset,
      state_ff == S_SHIFT && rsp_valid_ff && rsp_stall, state_ff == S_SHIFT,
      "result step left while output register still full")
   `DNR_ASSERT_NEXT(a_nonlast_returns, clock, reset, state_ff == S_ACC && !last_ff,
      state_ff == S_IDLE && !$rose(rsp_valid_ff), "non-last term produced a result")

endmodule

### rtl/core/dnr_mul32.sv
`timescale 1ns / 1ps

module dnr_mul32 (
   input  logic                              clock,
   input  logic [dnr_pkg::MUL_WIDTH-1:0]     op_a,
   input  logic [dnr_pkg::MUL_WIDTH-1:0]     op_b,
   output logic [2*dnr_pkg::MUL_WIDTH-1:0]   product
);
   import dnr_pkg::*;

   logic [2*MUL_WIDTH-1:0] product_ff;
   logic [2*MUL_WIDTH-1:0] product_in;

   // unsigned full product; callers handle sign by extension or correction
   assign product_in = {{MUL_WIDTH{1'b0}}, op_a} * {{MUL_WIDTH{1'b0}}, op_b};

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

### verif/dense_neuron_requantize_tb.sv
`timescale 1ns / 1ps

module dense_neuron_requantize_tb;
   import dnr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_TARGET = 1950;
   localparam int DRAIN_CYCLES = 16;

   typedef struct {
      logic signed [WEIGHT_WIDTH-1:0] weight;
      logic signed [ACT_WIDTH-1:0]    activation;
      logic signed [BIAS_WIDTH-1:0]   bias_value;
      logic                           last_term;
   } term_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic signed [WEIGHT_WIDTH-1:0] req_weight = '0;
   logic signed [ACT_WIDTH-1:0]    req_activation = '0;
   logic signed [BIAS_WIDTH-1:0]   req_bias_value = '0;
   logic                           req_last_term = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic signed [OUT_WIDTH-1:0]    rsp_neuron_out;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]     csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]      csr_data = '0;

   term_type                     pending_terms[$];
   logic signed [OUT_WIDTH-1:0]  expected_outputs[$];

   // Model copy of the datapath state and registers
   logic [ACC_WIDTH-1:0]         neuron_sum;
   logic signed [MULT_WIDTH-1:0] mult_cfg;
   logic [SHIFT_WIDTH-1:0]       shift_cfg;
   logic                         relu_cfg;
   logic signed [31:0]           term_product;

   int   mismatch_count = 0;
   int   items_queued = 0;
   int   cycle_count = 0;

   int   send_gap = 0;
   bit   send_calm = 1'b0;
   int   stall_left = 0;
   int   hold_left = 0;
   int   results_taken = 0;
   bit   recv_calm = 1'b0;
   int   next_stall;
   int   next_hold;

   dense_neuron_requantize dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_weight     (req_weight),
      .req_activation (req_activation),
      .req_bias_value (req_bias_value),
      .req_last_term  (req_last_term),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_neuron_out (rsp_neuron_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Scale, add shifted bias and rounding, shift, rectify, saturate
   function automatic logic signed [OUT_WIDTH-1:0] requantize_sum(
      logic [ACC_WIDTH-1:0] sum, logic signed [BIAS_WIDTH-1:0] bias);
      logic [63:0]        scaled;
      logic signed [63:0] level;
      scaled = sum * {{32{mult_cfg[31]}}, mult_cfg};
      scaled = scaled + ({{32{bias[31]}}, bias} << shift_cfg);
      if (shift_cfg != 0)
         scaled = scaled + (64'd1 << (shift_cfg - 6'd1));
      level = $signed(scaled) >>> shift_cfg;
      if (relu_cfg && level < 0)
         level = 0;
      if (level > OUT_MAX)
         return OUT_MAX;
      if (level < OUT_MIN)
         return OUT_MIN;
      return level[OUT_WIDTH-1:0];
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'hffff;
         3: return 16'(int'($urandom_range(0, 128)) - 64);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_bias();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(int'($urandom_range(0, 4000)) - 2000);
         default: return $urandom;
      endcase
   endfunction

   task automatic push_term(logic [15:0] w, logic [15:0] a, logic [31:0] b, logic last);
      term_type t;
      t.weight = w;
      t.activation = a;
      t.bias_value = b;
      t.last_term = last;
      pending_terms.push_back(t);
      items_queued++;
   endtask

   task automatic add_neuron(int len);
      for (int i = 0; i < len; i++)
         push_term(pick_sample(), pick_sample(), pick_bias(), i == len - 1);
   endtask

   // Wait until every request is sent and answered, then let the sequencer drain
   task automatic settle();
      while (pending_terms.size() != 0 || req_valid || expected_outputs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(logic [31:0] mult, logic [5:0] shift, logic relu, int n_items);
      int start;
      write_reg(CSR_REQUANT_MULT, mult);
      write_reg(CSR_SHIFT_AMOUNT, {26'd0, shift});
      write_reg(CSR_RELU_ENABLE, {31'd0, relu});
      start = items_queued;
      while (items_queued - start < n_items)
         add_neuron(($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                                : $urandom_range(1, 12));
      settle();
   endtask

   // Sender: one request per draw, with a random gap before the next
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_terms.size() != 0) begin
            term_type t;
            t = pending_terms.pop_front();
            req_weight <= t.weight;
            req_activation <= t.activation;
            req_bias_value <= t.bias_value;
            req_last_term <= t.last_term;
            req_valid <= 1'b1;
            send_gap <= send_calm ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 39) == 0)
               send_calm = !send_calm;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stall per result, plus two long hold-offs to back up the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
      end else begin
         next_stall = stall_left;
         next_hold = hold_left;
         if (rsp_valid && !rsp_stall) begin
            results_taken++;
            next_stall = recv_calm ? 0 : $urandom_range(0, 13);
            if (results_taken == 40 || results_taken == 160)
               next_hold = 400;
            if ($urandom_range(0, 29) == 0)
               recv_calm = !recv_calm;
         end else begin
            if (next_stall > 0)
               next_stall--;
            if (next_hold > 0)
               next_hold--;
         end
         stall_left <= next_stall;
         hold_left <= next_hold;
         rsp_stall <= (next_stall > 0) || (next_hold > 0);
      end
   end

   // Track register writes and accepted requests, queue the expected outputs
   always @(posedge clock) begin
      if (reset) begin
         neuron_sum = '0;
         mult_cfg = MULT_RESET;
         shift_cfg = SHIFT_RESET;
         relu_cfg = RELU_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_REQUANT_MULT: mult_cfg = csr_data;
               CSR_SHIFT_AMOUNT: shift_cfg = csr_data[SHIFT_WIDTH-1:0];
               CSR_RELU_ENABLE:  relu_cfg = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            term_product = 32'(req_weight) * 32'(req_activation);
            neuron_sum = neuron_sum + {{32{term_product[31]}}, term_product};
            if (req_last_term) begin
               expected_outputs.push_back(requantize_sum(neuron_sum, req_bias_value));
               neuron_sum = '0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outputs.size() == 0) begin
            $error("neuron_out: expected none, actual %0d", rsp_neuron_out);
            mismatch_count++;
         end else begin
            logic signed [OUT_WIDTH-1:0] want;
            want = expected_outputs.pop_front();
            if (rsp_neuron_out !== want) begin
               $error("neuron_out: expected %0d, actual %0d", want, rsp_neuron_out);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: mult 1, shift 16, ReLU on
      push_term(16'h7fff, 16'h7fff, 32'd0, 1'b1);
      push_term(16'h8000, 16'h8000, 32'h7fff_ffff, 1'b1);
      push_term(16'h8000, 16'h7fff, 32'h8000_0000, 1'b1);
      push_term(16'd0, 16'd0, 32'd0, 1'b1);
      push_term(16'd1, 16'd1, 32'hffff_ffff, 1'b1);
      // bias on the leading terms must be ignored
      push_term(16'd100, 16'd200, 32'd12345, 1'b0);
      push_term(-16'sd50, 16'd7, 32'h8000_0000, 1'b0);
      push_term(16'd3, 16'd4, -32'sd5, 1'b1);
      // saturate high from a run of maximum products
      for (int i = 0; i < 4; i++)
         push_term(16'h8000, 16'h8000, 32'h1234_5678, 1'b0);
      push_term(16'h7fff, 16'h7fff, 32'd0, 1'b1);
      // small values that land inside the output range
      push_term(16'd300, -16'sd20, 32'd2, 1'b0);
      push_term(16'd1000, 16'd900, -32'sd3, 1'b1);
      push_term(16'hffff, 16'h8000, 32'd1, 1'b1);
      settle();

      run_phase(32'd1, 6'd16, 1'b0, 60);
      run_phase(32'h8000_0000, 6'd62, 1'b0, 60);
      run_phase(32'h7fff_ffff, 6'd1, 1'b1, 60);
      run_phase(32'd1, 6'd0, 1'b0, 60);
      run_phase(32'hffff_ffff, 6'd63, 1'b0, 60);
      run_phase(32'h0001_2345, 6'd63, 1'b1, 40);
      run_phase(32'h8000_0000, 6'd0, 1'b1, 40);

      while (items_queued < ITEM_TARGET) begin
         logic [31:0] mult;
         logic [5:0]  shift;
         case ($urandom_range(0, 5))
            0: mult = 32'h8000_0000;
            1: mult = 32'h7fff_ffff;
            2: mult = $urandom;
            3: mult = 32'd1;
            default: mult = 32'(int'($urandom_range(0, 600)) - 300);
         endcase
         shift = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(8, 30));
         run_phase(mult, shift, 1'($urandom_range(0, 1)), 150);
      end

      settle();
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
